// ----- hw/rtl/sbm_pkg.sv -----
// sbm_pkg: shared types and constants for the smoothed bar meter.
// Holds the controller/datapath command and status structs, field widths,
// fixed-point constants and register indexes. No dependencies.
package sbm_pkg;

    localparam int LVL_W      = 17;   // Q16 level, 0..65536
    localparam int TGT_W      = 18;   // signed input target
    localparam int BAR_IDX_W  = 5;
    localparam int HEIGHT_W   = 12;
    localparam int INTEN_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int PROD_W     = 36;   // smoothing product, signed
    localparam int STEP_W     = 20;
    localparam int SQ_IN_W    = 33;   // level << 16
    localparam int SQ_W       = 34;
    localparam int ROOT_W     = 17;
    localparam int HPROD_W    = ROOT_W + HEIGHT_W;
    localparam int IPROD_W    = ROOT_W + INTEN_W;

    localparam logic [LVL_W-1:0] ONE_Q16 = 17'd65536;
    localparam logic [SQ_W-1:0]  SQ_TOP  = 34'h1_0000_0000;

    localparam logic [INTEN_W-1:0]  INTEN_BASE = 8'd100;
    localparam logic [INTEN_W-1:0]  INTEN_GAIN = 8'd155;
    localparam logic [INTEN_W-1:0]  INTEN_MAX  = 8'd255;
    localparam logic [HEIGHT_W-1:0] MIN_HEIGHT = 12'd2;

    localparam logic [LVL_W-1:0]    SMOOTH_RST = 17'd19661;
    localparam logic [LVL_W-1:0]    FLOOR_RST  = 17'd655;
    localparam logic [HEIGHT_W-1:0] MAXH_RST   = 12'd100;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXH   = 2'd2;

    typedef struct packed {
        logic load_tgt;
        logic clr_idx;
        logic inc_idx;
        logic rd_en;
        logic mul_en;
        logic upd_en;
        logic sq_start;
        logic scale_en;
        logic out_load;
    } sbm_cmd_t;

    typedef struct packed {
        logic sq_done;
        logic last_bar;
        logic out_free;
    } sbm_sts_t;

endpackage

// ----- hw/rtl/sbm_isqrt.sv -----
// sbm_isqrt: iterative integer square root, two operand bits per cycle.
// 17 steps per root, one-cycle done pulse after the last. Uses sbm_pkg.
module sbm_isqrt
    import sbm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [SQ_IN_W-1:0] operand,
    output logic               done,
    output logic [ROOT_W-1:0]  root
);

    logic            busy_reg;
    logic            done_reg;
    logic [SQ_W-1:0] v_reg;
    logic [SQ_W-1:0] res_reg;
    logic [SQ_W-1:0] bit_reg;
    logic [SQ_W-1:0] trial;
    logic [SQ_W-1:0] v_next;
    logic [SQ_W-1:0] res_next;

    always_comb begin
        trial = res_reg + bit_reg;
        if (v_reg >= trial) begin
            v_next   = v_reg - trial;
            res_next = (res_reg >> 1) + bit_reg;
        end else begin
            v_next   = v_reg;
            res_next = res_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_reg[0]) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg   <= SQ_W'(operand);
            res_reg <= '0;
            bit_reg <= SQ_TOP;
        end else if (busy_reg) begin
            v_reg   <= v_next;
            res_reg <= res_next;
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

// ----- hw/rtl/sbm_ctrl.sv -----
// sbm_ctrl: sequencer for the bar meter. Takes input items and steps the
// datapath through read, smooth, root, scale and emit per bar. Uses sbm_pkg.
module sbm_ctrl
    import sbm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_kind,
    output logic     s_ready,
    input  sbm_sts_t sts,
    output sbm_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_UPD   = 3'd3;
    localparam logic [2:0] ST_SQS   = 3'd4;
    localparam logic [2:0] ST_SQW   = 3'd5;
    localparam logic [2:0] ST_SCALE = 3'd6;
    localparam logic [2:0] ST_EMIT  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_kind == KIND_TICK) begin
                        cmd.clr_idx = 1'b1;
                        state_next  = ST_READ;
                    end else begin
                        cmd.load_tgt = 1'b1;
                    end
                end
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                cmd.upd_en = 1'b1;
                state_next = ST_SQS;
            end
            ST_SQS: begin
                cmd.sq_start = 1'b1;
                state_next   = ST_SQW;
            end
            ST_SQW: begin
                if (sts.sq_done) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                cmd.scale_en = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    if (sts.last_bar) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.inc_idx = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hw/rtl/sbm_datapath.sv -----
// sbm_datapath: config registers, target/level memories, smoothing multiply,
// root unit, output scaling and result register. Uses sbm_pkg, sbm_isqrt.
module sbm_datapath
    import sbm_pkg::*;
#(
    parameter int NUM_BARS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sbm_cmd_t               cmd,
    output sbm_sts_t               sts,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [BAR_IDX_W-1:0]   s_bar_index,
    input  logic signed [TGT_W-1:0] s_target_value,
    input  logic                   m_ready,
    output logic                   m_valid,
    output logic [BAR_IDX_W-1:0]   m_bar_number,
    output logic [HEIGHT_W-1:0]    m_bar_height,
    output logic [INTEN_W-1:0]     m_intensity,
    output logic                   m_last
);

    localparam int IDX_W = $clog2(NUM_BARS);
    localparam int EXT_W = IDX_W + BAR_IDX_W;

    // configuration
    logic [LVL_W-1:0]    smooth_reg;
    logic [LVL_W-1:0]    floor_reg;
    logic [HEIGHT_W-1:0] maxh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smooth_reg <= SMOOTH_RST;
            floor_reg  <= FLOOR_RST;
            maxh_reg   <= MAXH_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SMOOTH: smooth_reg <= cfg_wdata[LVL_W-1:0];
                CFG_FLOOR:  floor_reg  <= cfg_wdata[LVL_W-1:0];
                CFG_MAXH:   maxh_reg   <= cfg_wdata[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // target load with clamp to 0..1.0
    logic [LVL_W-1:0] load_lvl;
    logic [EXT_W-1:0] load_ext;
    logic             load_in_range;
    logic [IDX_W-1:0] load_addr;

    always_comb begin
        if (s_target_value[TGT_W-1]) begin
            load_lvl = '0;
        end else if (s_target_value[LVL_W-1:0] > ONE_Q16) begin
            load_lvl = ONE_Q16;
        end else begin
            load_lvl = s_target_value[LVL_W-1:0];
        end
    end

    assign load_ext      = EXT_W'(s_bar_index);
    assign load_in_range = (load_ext < EXT_W'(NUM_BARS));
    assign load_addr     = load_ext[IDX_W-1:0];

    // bar counter
    logic [IDX_W-1:0] idx_reg;
    logic [EXT_W-1:0] idx_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (cmd.clr_idx) begin
            idx_reg <= '0;
        end else if (cmd.inc_idx) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    assign idx_ext = EXT_W'(idx_reg);

    // level stores; an entry never written reads as zero
    logic [LVL_W-1:0]    tgt_mem [NUM_BARS];
    logic [LVL_W-1:0]    cur_mem [NUM_BARS];
    logic [NUM_BARS-1:0] tgt_vld_reg;
    logic [NUM_BARS-1:0] cur_vld_reg;
    logic [LVL_W-1:0]    tgt_rd_reg;
    logic [LVL_W-1:0]    cur_rd_reg;
    logic                tgt_rd_vld_reg;
    logic                cur_rd_vld_reg;
    logic [LVL_W-1:0]    tgt_eff;
    logic [LVL_W-1:0]    cur_eff;
    logic [LVL_W-1:0]    new_lvl;

    always_ff @(posedge aclk) begin
        if (cmd.load_tgt && load_in_range) begin
            tgt_mem[load_addr] <= load_lvl;
        end
        if (cmd.upd_en) begin
            cur_mem[idx_reg] <= new_lvl;
        end
        if (cmd.rd_en) begin
            tgt_rd_reg     <= tgt_mem[idx_reg];
            cur_rd_reg     <= cur_mem[idx_reg];
            tgt_rd_vld_reg <= tgt_vld_reg[idx_reg];
            cur_rd_vld_reg <= cur_vld_reg[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tgt_vld_reg <= '0;
            cur_vld_reg <= '0;
        end else begin
            if (cmd.load_tgt && load_in_range) begin
                tgt_vld_reg[load_addr] <= 1'b1;
            end
            if (cmd.upd_en) begin
                cur_vld_reg[idx_reg] <= 1'b1;
            end
        end
    end

    assign tgt_eff = tgt_rd_vld_reg ? tgt_rd_reg : '0;
    assign cur_eff = cur_rd_vld_reg ? cur_rd_reg : '0;

    // smoothing: step = floor(factor * (target - current) / 65536)
    logic signed [TGT_W-1:0]  diff;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [STEP_W-1:0] step;
    logic signed [STEP_W-1:0] nv;
    logic [LVL_W-1:0]         sat_lvl;
    logic [LVL_W-1:0]         lvl_reg;

    assign diff = $signed({1'b0, tgt_eff}) - $signed({1'b0, cur_eff});

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= PROD_W'($signed({1'b0, smooth_reg})) * PROD_W'(diff);
        end
    end

    // arithmetic shift gives the floor toward minus infinity
    assign step = prod_reg[PROD_W-1-:STEP_W];
    assign nv   = $signed({{(STEP_W-LVL_W){1'b0}}, cur_eff}) + step;

    always_comb begin
        if (nv[STEP_W-1]) begin
            sat_lvl = '0;
        end else if (nv[STEP_W-2:0] > (STEP_W-1)'(ONE_Q16)) begin
            sat_lvl = ONE_Q16;
        end else begin
            sat_lvl = nv[LVL_W-1:0];
        end
        new_lvl = (sat_lvl < floor_reg) ? '0 : sat_lvl;
    end

    always_ff @(posedge aclk) begin
        if (cmd.upd_en) begin
            lvl_reg <= new_lvl;
        end
    end

    // square root of level in Q16
    logic              sq_done;
    logic [ROOT_W-1:0] root;

    sbm_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.sq_start),
        .operand ({lvl_reg, 16'd0}),
        .done    (sq_done),
        .root    (root)
    );

    // output scaling
    logic [HPROD_W-1:0]  hprod_reg;
    logic [IPROD_W-1:0]  iprod_reg;
    logic [HEIGHT_W:0]   h_raw;
    logic [INTEN_W+1:0]  inten_sum;
    logic [HEIGHT_W-1:0] height;
    logic [INTEN_W-1:0]  inten;

    always_ff @(posedge aclk) begin
        if (cmd.scale_en) begin
            hprod_reg <= HPROD_W'(root) * HPROD_W'(maxh_reg);
            iprod_reg <= IPROD_W'(root) * IPROD_W'(INTEN_GAIN);
        end
    end

    assign h_raw     = hprod_reg[HPROD_W-1:16];
    assign inten_sum = (INTEN_W+2)'(INTEN_BASE) + (INTEN_W+2)'(iprod_reg[IPROD_W-1:16]);

    always_comb begin
        height = (h_raw < (HEIGHT_W+1)'(MIN_HEIGHT)) ? MIN_HEIGHT : h_raw[HEIGHT_W-1:0];
        inten  = (inten_sum > (INTEN_W+2)'(INTEN_MAX)) ? INTEN_MAX : inten_sum[INTEN_W-1:0];
    end

    // result register
    logic                 m_valid_reg;
    logic [BAR_IDX_W-1:0] m_bar_number_reg;
    logic [HEIGHT_W-1:0]  m_bar_height_reg;
    logic [INTEN_W-1:0]   m_intensity_reg;
    logic                 m_last_reg;
    logic                 last_bar;

    assign last_bar = (idx_reg == IDX_W'(NUM_BARS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_bar_number_reg <= idx_ext[BAR_IDX_W-1:0];
            m_bar_height_reg <= height;
            m_intensity_reg  <= inten;
            m_last_reg       <= last_bar;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_bar_number = m_bar_number_reg;
    assign m_bar_height = m_bar_height_reg;
    assign m_intensity  = m_intensity_reg;
    assign m_last       = m_last_reg;

    assign sts.sq_done  = sq_done;
    assign sts.last_bar = last_bar;
    assign sts.out_free = !m_valid_reg || m_ready;

endmodule

// ----- hw/rtl/smoothed_bar_meter.sv -----
// smoothed_bar_meter: smoothed bar meter with one Q16 level per bar.
// Input channel s_*: kind 0 loads one bar target (clamped to 0..1.0), kind 1
// is a display tick. A load gives no result and leaves s_ready high.
// A tick moves every level toward its target, snaps small levels to zero and
// emits one item per bar on m_*, in bar order, with m_last on the final bar.
// Each bar goes through memory read, smoothing multiply, update, then the
// 17-step square root unit, which dominates, followed by scaling and the output
// register. s_ready is low while a tick runs and returns high once the last
// bar sits in the output register.
// If the receiver stalls, the sequencer holds each bar until the output
// register frees up; no item is dropped.
// Config (cfg_wr_en/cfg_index/cfg_wdata) must be written only while idle; the block does not enforce this.
// Reset (aresetn low, synchronous) restores config defaults and makes every
// target and level read as zero at once through per-entry valid bits.
// Depends on sbm_pkg, sbm_ctrl, sbm_datapath, sbm_isqrt.
module smoothed_bar_meter
    import sbm_pkg::*;
#(
    parameter int NUM_BARS = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_kind,
    input  logic [BAR_IDX_W-1:0]    s_bar_index,
    input  logic signed [TGT_W-1:0] s_target_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [BAR_IDX_W-1:0]    m_bar_number,
    output logic [HEIGHT_W-1:0]     m_bar_height,
    output logic [INTEN_W-1:0]      m_intensity,
    output logic                    m_last
);

    sbm_cmd_t cmd;
    sbm_sts_t sts;

    sbm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sbm_datapath #(
        .NUM_BARS (NUM_BARS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_bar_index    (s_bar_index),
        .s_target_value (s_target_value),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_bar_number   (m_bar_number),
        .m_bar_height   (m_bar_height),
        .m_intensity    (m_intensity),
        .m_last         (m_last)
    );

endmodule

// ----- hw/rtl/sbm_checker.sv -----
// sbm_checker: port-level checks for smoothed_bar_meter, attached by bind.
// Uses sbm_pkg.
module sbm_checker
    import sbm_pkg::*;
#(
    parameter int NUM_BARS = 32
) (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    s_kind,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [BAR_IDX_W-1:0]    m_bar_number,
    input logic [HEIGHT_W-1:0]     m_bar_height,
    input logic [INTEN_W-1:0]      m_intensity,
    input logic                    m_last
);

    // stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_bar_number)
            && $stable(m_bar_height) && $stable(m_intensity) && $stable(m_last))
        else $error("result item changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // an accepted tick makes the block busy, so s_ready goes low
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_kind == KIND_TICK) |=> !s_ready)
        else $error("input taken right after a tick");

    a_last_bar: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_bar_number == BAR_IDX_W'(NUM_BARS - 1))
        else $error("last flag on wrong bar");

    a_floor_vals: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_bar_height >= MIN_HEIGHT) && (m_intensity >= INTEN_BASE))
        else $error("height or intensity below floor");

endmodule

bind smoothed_bar_meter sbm_checker #(.NUM_BARS(NUM_BARS)) u_sbm_checker (.*);

// ----- dv/smoothed_bar_meter_test.sv -----
// Self-checking testbench for smoothed_bar_meter: target loads and display ticks go in,
// per-bar height/intensity items are predicted in-line and compared in order.
// Depends on sbm_pkg and the smoothed_bar_meter RTL.
module smoothed_bar_meter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sbm_pkg::*;

    localparam int NUM_BARS       = 32;
    localparam int SETTLE_CYCLES  = 40;    // idle margin after the queues drain, leave plenty
    localparam int RX_HOLD_CYCLES = 2000;  // longer than a full tick

    typedef struct {
        logic                    kind;
        logic [BAR_IDX_W-1:0]    bar;
        logic signed [TGT_W-1:0] target;
    } meter_cmd_t;

    typedef struct {
        logic [BAR_IDX_W-1:0] bar;
        logic [HEIGHT_W-1:0]  height;
        logic [INTEN_W-1:0]   inten;
        logic                 last;
    } bar_report_t;

    logic                    aclk           = 1'b0;
    logic                    aresetn        = 1'b0;
    logic                    cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index      = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata      = '0;
    logic                    s_valid        = 1'b0;
    logic                    s_ready;
    logic                    s_kind         = 1'b0;
    logic [BAR_IDX_W-1:0]    s_bar_index    = '0;
    logic signed [TGT_W-1:0] s_target_value = '0;
    logic                    m_valid;
    logic                    m_ready        = 1'b0;
    logic [BAR_IDX_W-1:0]    m_bar_number;
    logic [HEIGHT_W-1:0]     m_bar_height;
    logic [INTEN_W-1:0]      m_intensity;
    logic                    m_last;

    smoothed_bar_meter #(.NUM_BARS(NUM_BARS)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_bar_index   (s_bar_index),
        .s_target_value(s_target_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_bar_number  (m_bar_number),
        .m_bar_height  (m_bar_height),
        .m_intensity   (m_intensity),
        .m_last        (m_last)
    );

    always #2 aclk = ~aclk;

    // shadow of the block's registers and level memories
    logic [LVL_W-1:0]    smooth_cfg = SMOOTH_RST;
    logic [LVL_W-1:0]    floor_cfg  = FLOOR_RST;
    logic [HEIGHT_W-1:0] maxh_cfg   = MAXH_RST;
    logic [LVL_W-1:0]    target_lvl [NUM_BARS];
    logic [LVL_W-1:0]    current_lvl[NUM_BARS];

    meter_cmd_t  meter_cmds[$];
    bar_report_t due_bars[$];
    meter_cmd_t  next_cmd;
    bar_report_t oldest_bar;

    int tx_idle_pct = 11;
    int rx_idle_pct = 78;
    int hold_reqs   = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int mismatches  = 0;

    initial begin
        for (int i = 0; i < NUM_BARS; i++) begin
            target_lvl[i]  = '0;
            current_lvl[i] = '0;
        end
    end

    // one tick of exponential smoothing for a single bar
    function automatic logic [LVL_W-1:0] smoothed(input logic [LVL_W-1:0] lvl,
                                                  input logic [LVL_W-1:0] goal);
        longint l, g, sf, fl, prod, nxt;
        l    = longint'(lvl);
        g    = longint'(goal);
        sf   = longint'(smooth_cfg);
        fl   = longint'(floor_cfg);
        prod = sf * (g - l);
        nxt  = l + (prod >>> 16);   // arithmetic shift floors negative steps
        if (nxt < 0)
            nxt = 0;
        if (nxt > ONE_Q16)
            nxt = ONE_Q16;
        if (nxt < fl)
            nxt = 0;
        return nxt[LVL_W-1:0];
    endfunction

    // floor(sqrt(lvl * 65536)), built one result bit at a time
    function automatic longint level_root(input logic [LVL_W-1:0] lvl);
        longint v, r, t;
        v = longint'(lvl);
        v = v << 16;
        r = 0;
        for (int b = 16; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    task automatic advance_meter(input logic kind, input logic [BAR_IDX_W-1:0] bar,
                                 input logic signed [TGT_W-1:0] tgt);
        int          tv;
        longint      root, h, inten;
        bar_report_t rep;
        tv = int'(tgt);
        if (kind == KIND_LOAD) begin
            if (tv < 0)
                target_lvl[bar] = '0;
            else if (tv > ONE_Q16)
                target_lvl[bar] = ONE_Q16;
            else
                target_lvl[bar] = tv[LVL_W-1:0];
        end else begin
            for (int i = 0; i < NUM_BARS; i++)
                current_lvl[i] = smoothed(current_lvl[i], target_lvl[i]);
            for (int i = 0; i < NUM_BARS; i++) begin
                root  = level_root(current_lvl[i]);
                h     = (root * maxh_cfg) >> 16;
                inten = INTEN_BASE + ((root * INTEN_GAIN) >> 16);
                if (h < MIN_HEIGHT)
                    h = MIN_HEIGHT;
                if (inten > INTEN_MAX)
                    inten = INTEN_MAX;
                rep.bar    = i[BAR_IDX_W-1:0];
                rep.height = h[HEIGHT_W-1:0];
                rep.inten  = inten[INTEN_W-1:0];
                rep.last   = (i == NUM_BARS - 1);
                due_bars.push_back(rep);
            end
        end
    endtask

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            mismatches++;
        end
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                advance_meter(s_kind, s_bar_index, s_target_value);
            if (!s_valid || s_ready) begin
                if (meter_cmds.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    next_cmd = meter_cmds.pop_front();
                    s_valid        <= 1'b1;
                    s_kind         <= next_cmd.kind;
                    s_bar_index    <= next_cmd.bar;
                    s_target_value <= next_cmd.target;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_bars.size() == 0) begin
                    $error("bar item %0d arrived with nothing expected", m_bar_number);
                    mismatches++;
                end else begin
                    oldest_bar = due_bars.pop_front();
                    check_field("bar_number", 32'(oldest_bar.bar), 32'(m_bar_number));
                    check_field("bar_height", 32'(oldest_bar.height), 32'(m_bar_height));
                    check_field("intensity", 32'(oldest_bar.inten), 32'(m_intensity));
                    check_field("last", 32'(oldest_bar.last), 32'(m_last));
                end
            end
            if (hold_seen != hold_reqs) begin
                hold_seen = hold_reqs;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    task automatic queue_cmd(input logic kind, input logic [BAR_IDX_W-1:0] bar, input int tgt);
        meter_cmd_t c;
        c.kind   = kind;
        c.bar    = bar;
        c.target = tgt[TGT_W-1:0];
        meter_cmds.push_back(c);
    endtask

    function automatic int rand_target();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(ONE_Q16 + 1, 131071);
            1:       return -int'($urandom_range(1, 131072));
            2:       return 0;
            3:       return ONE_Q16;
            default: return $urandom_range(0, ONE_Q16);
        endcase
    endfunction

    task automatic wait_meter_quiet(input int settle);
        while (meter_cmds.size() != 0 || s_valid || due_bars.size() != 0)
            @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic set_meter_regs(input logic [LVL_W-1:0] sf, input logic [LVL_W-1:0] fl,
                                  input logic [HEIGHT_W-1:0] mh);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SMOOTH;
        cfg_wdata <= sf;
        @(posedge aclk);
        cfg_index <= CFG_FLOOR;
        cfg_wdata <= fl;
        @(posedge aclk);
        cfg_index <= CFG_MAXH;
        cfg_wdata <= CFG_DATA_W'(mh);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        smooth_cfg = sf;
        floor_cfg  = fl;
        maxh_cfg   = mh;
    endtask

    // mode 0: sender idles a little, receiver a lot; mode 1 swapped; mode 2 no idling
    task automatic run_phase(input logic [LVL_W-1:0] sf, input logic [LVL_W-1:0] fl,
                             input logic [HEIGHT_W-1:0] mh, input int mode, input int n,
                             input bit hold);
        int made, loads;
        bit paused, held;
        set_meter_regs(sf, fl, mh);
        case (mode)
            0:       begin tx_idle_pct = 11; rx_idle_pct = 78; end
            1:       begin tx_idle_pct = 78; rx_idle_pct = 11; end
            default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        endcase
        made   = 0;
        paused = 0;
        held   = 0;
        while (made < n) begin
            if (!paused && made >= n / 2) begin
                wait_meter_quiet(0);
                paused = 1;
            end
            if ($urandom_range(0, 9) < 8) begin
                // a few target loads followed by a tick
                loads = $urandom_range(1, 6);
                repeat (loads) queue_cmd(KIND_LOAD, BAR_IDX_W'($urandom_range(0, 31)),
                                         rand_target());
                queue_cmd(KIND_TICK, BAR_IDX_W'($urandom_range(0, 31)), rand_target());
                made += loads + 1;
            end else begin
                queue_cmd($urandom_range(0, 1) ? KIND_TICK : KIND_LOAD,
                          BAR_IDX_W'($urandom_range(0, 31)), rand_target());
                made++;
            end
            if (hold && !held && made > 8) begin
                hold_reqs++;
                held = 1;
            end
        end
        wait_meter_quiet(SETTLE_CYCLES);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // clamping and bar-range extremes under the reset configuration
        queue_cmd(KIND_LOAD, 0, 131071);
        queue_cmd(KIND_LOAD, 1, -131072);
        queue_cmd(KIND_LOAD, 31, ONE_Q16);
        queue_cmd(KIND_LOAD, 2, ONE_Q16 + 1);
        queue_cmd(KIND_LOAD, 3, -1);
        queue_cmd(KIND_LOAD, 4, 1);
        queue_cmd(KIND_LOAD, 16, 32768);
        queue_cmd(KIND_LOAD, 15, 43690);
        queue_cmd(KIND_TICK, 0, 0);
        queue_cmd(KIND_TICK, 31, -1);
        queue_cmd(KIND_TICK, 0, 0);
        queue_cmd(KIND_LOAD, 0, 0);
        queue_cmd(KIND_LOAD, 31, 0);
        queue_cmd(KIND_LOAD, 4, 700);
        queue_cmd(KIND_TICK, 0, 0);
        queue_cmd(KIND_TICK, 0, 0);
        queue_cmd(KIND_LOAD, 10, -5);
        queue_cmd(KIND_TICK, 21, 131071);
        wait_meter_quiet(SETTLE_CYCLES);

        run_phase(ONE_Q16, 0, 4095, 0, 45, 0);
        run_phase(0, FLOOR_RST, 2, 0, 15, 0);
        run_phase(131071, ONE_Q16, MAXH_RST, 1, 30, 1);
        run_phase(LVL_W'($urandom_range(0, 131071)), LVL_W'($urandom_range(0, 4000)),
                  HEIGHT_W'($urandom_range(0, 4095)), 1, 50, 0);
        run_phase(100000, 131071, 0, 2, 25, 0);
        run_phase(SMOOTH_RST, FLOOR_RST, MAXH_RST, 2, 40, 1);
        run_phase(LVL_W'($urandom_range(0, 131071)), LVL_W'($urandom_range(0, 4000)),
                  HEIGHT_W'($urandom_range(0, 4095)), 2, 45, 0);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/sbm_pkg.sv
hw/rtl/sbm_isqrt.sv
hw/rtl/sbm_ctrl.sv
hw/rtl/sbm_datapath.sv
hw/rtl/smoothed_bar_meter.sv
hw/rtl/sbm_checker.sv
dv/smoothed_bar_meter_test.sv
